@@ hdl/rcg_pkg.sv @@
// ----------------------------------------------------------------------------
// rcg_pkg
// Shared constants, types and controller/datapath links for the reader
// command gate.
// ----------------------------------------------------------------------------
package rcg_pkg;

  // window of stored magnitudes (power of two)
  localparam int WINDOW_LEN = 256;
  localparam int WIN_AW     = $clog2(WINDOW_LEN);

  // field and register widths
  localparam int SMP_W     = 16;
  localparam int MAG_W     = 16;
  localparam int WSUM_W    = MAG_W + WIN_AW;
  localparam int PW_W      = 12;
  localparam int T1_W      = 10;
  localparam int UG_W      = 17;
  localparam int TH_W      = 8;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 17;
  localparam int PC_W      = 8;
  localparam int CMP_W     = MAG_W + TH_W + WIN_AW;

  // statistics datapath widths
  localparam int STAT_DIV_SH = 2;                   // span is T1 / 4
  localparam int N_W         = T1_W - STAT_DIV_SH;
  localparam int SUM_W       = MAG_W + N_W;
  localparam int SSQ_W       = 2 * MAG_W + N_W;
  localparam int SQ_SPLIT    = SSQ_W / 2;
  localparam int PART_W      = SQ_SPLIT + N_W;
  localparam int VAR_W       = 2 * SUM_W;
  localparam int SQ_IN_W     = VAR_W;
  localparam int SQ_OUT_W    = SQ_IN_W / 2;
  localparam int DIV_W       = SUM_W;

  // stream widths
  localparam int IN_DATA_W  = 2 * SMP_W;
  localparam int OUT_DATA_W = 2 * SMP_W + 4 * MAG_W;
  localparam int OUT_USER_W = 4;

  // fixed numbers of the gate rules
  localparam int MIN_PULSES = 5;
  localparam int STAT_MUL   = 3;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [PC_W-1:0]  PULSE_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T1          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNGATE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH      = 2'd3;

  // configuration reset values
  localparam logic [PW_W-1:0] PW_RST = 12'd25;
  localparam logic [T1_W-1:0] T1_RST = 10'd400;
  localparam logic [UG_W-1:0] UG_RST = 17'd4000;
  localparam logic [TH_W-1:0] TH_RST = 8'd128;

  // commands from the controller
  typedef struct packed {
    logic accept;
    logic mul_i;
    logic mul_q;
    logic mag_go;
    logic win_upd;
    logic thr_mul;
    logic gate_upd;
    logic walk_init;
    logic walk;
    logic nsq_lo;
    logic nsq_hi;
    logic ssq;
    logic var_calc;
    logic sd_go;
    logic mean_go;
    logic std_go;
    logic cap_mean;
    logic cap_std;
    logic load_out;
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic walk_done;
    logic need_stats;
    logic has_result;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/rcg_isqrt.sv @@
// ----------------------------------------------------------------------------
// rcg_isqrt
// Iterative floored square root, two result bits per cycle.
// ----------------------------------------------------------------------------
module rcg_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rcg_pkg::SQ_IN_W-1:0]  radicand,
  output logic                         done,
  output logic [rcg_pkg::SQ_OUT_W-1:0] root
);
  import rcg_pkg::*;

  localparam int ITER  = SQ_OUT_W / 2;
  localparam int IT_W  = $clog2(ITER);
  localparam int REM_W = SQ_OUT_W + 2;

  logic              busy;
  logic [IT_W-1:0]   iter;
  logic [SQ_IN_W-1:0] rad;
  logic [REM_W-1:0]  rem;
  logic [SQ_IN_W-1:0] rad_next;
  logic [REM_W-1:0]  rem_next;
  logic [SQ_OUT_W-1:0] root_next;

  // two digit steps of the restoring square root
  always_comb begin
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] test;
    rad_next  = rad;
    rem_next  = rem;
    root_next = root;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_next, rad_next[SQ_IN_W-1 -: 2]};
      test  = (REM_W+2)'({root_next, 2'b01});
      if (trial >= test) begin
        rem_next  = REM_W'(trial - test);
        root_next = {root_next[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_next  = trial[REM_W-1:0];
        root_next = {root_next[SQ_OUT_W-2:0], 1'b0};
      end
      rad_next = {rad_next[SQ_IN_W-3:0], 2'b00};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad_next;
      rem  <= rem_next;
      root <= root_next;
      iter <= iter + 1'b1;
      if (iter == IT_W'(ITER - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/rcg_div.sv @@
// ----------------------------------------------------------------------------
// rcg_div
// Restoring divider by the span length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcg_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rcg_pkg::DIV_W-1:0] dividend,
  input  logic [rcg_pkg::N_W-1:0]   divisor,
  output logic                      done,
  output logic [rcg_pkg::DIV_W-1:0] quotient
);
  import rcg_pkg::*;

  localparam int IT_W = $clog2(DIV_W);

  logic            busy;
  logic [IT_W-1:0] iter;
  logic [N_W-1:0]  rem;
  logic [N_W-1:0]  dvs;
  logic [N_W:0]    trial;

  assign trial = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      iter     <= '0;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs}) begin
        rem      <= N_W'(trial - {1'b0, dvs});
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= trial[N_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
      iter <= iter + 1'b1;
      if (iter == IT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/rcg_dp.sv @@
// ----------------------------------------------------------------------------
// rcg_dp
// Datapath: magnitude, window store and sum, edge compare, gate counters,
// span statistics and the output register.
// ----------------------------------------------------------------------------
module rcg_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcg_pkg::CFG_W-1:0]      cfg_data,
  input  logic [rcg_pkg::IN_DATA_W-1:0]  in_data,
  input  logic                           in_nak,
  input  rcg_pkg::cmd_t                  cmd,
  output rcg_pkg::sts_t                  sts,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output logic [rcg_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [rcg_pkg::OUT_USER_W-1:0] m_tuser
);
  import rcg_pkg::*;

  typedef enum logic [1:0] {
    GM_CLOSED = 2'd0,
    GM_OPEN   = 2'd1,
    GM_RESET  = 2'd2,
    GM_SPARE  = 2'd3
  } gate_mode_t;

  // configuration
  logic [PW_W-1:0] pulse_width;
  logic [T1_W-1:0] t1;
  logic [UG_W-1:0] ungate;
  logic [TH_W-1:0] thresh;

  // sample and magnitude
  logic signed [SMP_W-1:0] in_i;
  logic signed [SMP_W-1:0] in_q;
  logic                    nak;
  logic [2*SMP_W-1:0]      pow_acc;
  logic [MAG_W-1:0]        mag;

  // window
  logic [MAG_W-1:0]  win_mem [WINDOW_LEN];
  logic              win_vld [WINDOW_LEN];
  logic [WIN_AW-1:0] win_pos;
  logic [WSUM_W-1:0] win_sum;
  logic [WIN_AW-1:0] rd_addr;
  logic [MAG_W-1:0]  mem_q;
  logic              vld_q;
  logic [MAG_W-1:0]  rd_val;
  logic [CMP_W-1:0]  rhs;
  logic [CMP_W-1:0]  lhs;

  // gate state
  gate_mode_t       mode, mode_next;
  logic [CNT_W-1:0] sample_count, sample_count_next;
  logic             low_seen, low_seen_next;
  logic [PC_W-1:0]  pulse_count, pulse_count_next;
  logic             res_sv, res_sv_next;
  logic             res_stv, res_stv_next;
  logic             res_kind, res_kind_next;
  logic             res_op, res_op_next;

  // statistics walk
  logic [N_W-1:0]    span_n;
  logic [WIN_AW-1:0] walk_idx;
  logic [N_W-1:0]    walk_cnt;
  logic              walk_p1;
  logic              walk_p2;
  logic [SUM_W-1:0]  st_sum;
  logic [SSQ_W-1:0]  st_sumsq;
  logic [2*MAG_W-1:0] sq_reg;
  logic [MAG_W-1:0]  st_max;
  logic [MAG_W-1:0]  st_min;
  logic [PART_W-1:0] part_lo;
  logic [PART_W-1:0] part_hi;
  logic [VAR_W-1:0]  sum_sq;
  logic [VAR_W-1:0]  var_r;
  logic [MAG_W-1:0]  st_mean;
  logic [MAG_W-1:0]  st_std;

  // shared units
  logic                sqrt_done;
  logic [SQ_OUT_W-1:0] sqrt_root;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;

  assign span_n = t1[T1_W-1:STAT_DIV_SH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width <= PW_RST;
      t1          <= T1_RST;
      ungate      <= UG_RST;
      thresh      <= TH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PULSE_WIDTH: pulse_width <= cfg_data[PW_W-1:0];
        CFG_T1:          t1          <= cfg_data[T1_W-1:0];
        CFG_UNGATE:      ungate      <= cfg_data[UG_W-1:0];
        CFG_THRESH:      thresh      <= cfg_data[TH_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture and i*i + q*q in two steps, i term first
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_i <= in_data[SMP_W-1:0];
      in_q <= in_data[2*SMP_W-1:SMP_W];
      nak  <= in_nak;
    end
    if (cmd.mul_i) begin
      pow_acc <= unsigned'((2*SMP_W)'(in_i) * (2*SMP_W)'(in_i));
    end
    if (cmd.mul_q) begin
      pow_acc <= pow_acc + unsigned'((2*SMP_W)'(in_q) * (2*SMP_W)'(in_q));
    end
  end

  // shared square root: magnitude or span variance
  rcg_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mag_go | cmd.sd_go),
    .radicand (cmd.sd_go ? var_r : SQ_IN_W'(pow_acc)),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // shared divider: mean or deviation over span length
  rcg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mean_go | cmd.std_go),
    .dividend (cmd.std_go ? DIV_W'(sqrt_root) : st_sum),
    .divisor  (span_n),
    .done     (div_done),
    .quotient (div_quo)
  );

  // window memory, read every cycle at the current or walk address
  assign rd_addr = cmd.walk ? walk_idx : win_pos;

  always_ff @(posedge clk) begin
    if (cmd.win_upd) begin
      win_mem[win_pos] <= sqrt_root[MAG_W-1:0];
    end
    mem_q <= win_mem[rd_addr];
  end

  // entry valid bits stand in for the cleared store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        win_vld[k] <= 1'b0;
      end
      vld_q <= 1'b0;
    end else begin
      if (cmd.win_upd) begin
        win_vld[win_pos] <= 1'b1;
      end
      vld_q <= win_vld[rd_addr];
    end
  end

  assign rd_val = vld_q ? mem_q : '0;

  // window sum, position and threshold product
  always_ff @(posedge clk) begin
    if (rst) begin
      win_pos <= '0;
      win_sum <= '0;
    end else if (cmd.win_upd) begin
      win_sum <= win_sum - WSUM_W'(rd_val) + WSUM_W'(sqrt_root[MAG_W-1:0]);
      win_pos <= win_pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_upd) begin
      mag <= sqrt_root[MAG_W-1:0];
    end
    if (cmd.thr_mul) begin
      rhs <= win_sum * thresh;
    end
  end

  assign lhs = {mag, {(TH_W + WIN_AW){1'b0}}};

  // gate rules for one sample
  always_comb begin
    logic lo;
    logic hi;
    lo = lhs < rhs;
    hi = lhs > rhs;
    mode_next         = mode;
    sample_count_next = sample_count;
    low_seen_next     = low_seen;
    pulse_count_next  = pulse_count;
    res_sv_next       = 1'b0;
    res_stv_next      = 1'b0;
    res_kind_next     = 1'b0;
    res_op_next       = 1'b0;
    if (mode_next == GM_RESET) begin
      mode_next         = GM_CLOSED;
      sample_count_next = '0;
    end
    if (mode_next != GM_OPEN) begin
      mode_next = GM_CLOSED;
      if (sample_count_next != COUNT_MAX) begin
        sample_count_next = sample_count_next + 1'b1;
      end
      if (lo && !low_seen_next) begin
        sample_count_next = '0;
        low_seen_next     = 1'b1;
      end
      if (low_seen_next && hi) begin
        if (sample_count_next > CNT_W'(pulse_width >> 1)) begin
          if (pulse_count_next != PULSE_MAX) begin
            pulse_count_next = pulse_count_next + 1'b1;
          end
          low_seen_next = 1'b0;
        end else begin
          pulse_count_next = '0;
        end
        sample_count_next = '0;
      end
      if (sample_count_next == CNT_W'(span_n) * CNT_W'(STAT_MUL) && span_n != '0) begin
        res_stv_next = 1'b1;
      end
      if (sample_count_next > CNT_W'(t1)) begin
        if (!low_seen_next && pulse_count_next > PC_W'(MIN_PULSES)) begin
          mode_next   = GM_OPEN;
          res_op_next = 1'b1;
        end
        pulse_count_next  = '0;
        sample_count_next = '0;
      end
    end
    if (mode_next == GM_OPEN) begin
      if (sample_count_next == CNT_W'(t1) * CNT_W'(STAT_MUL) && span_n != '0) begin
        res_stv_next  = 1'b1;
        res_kind_next = 1'b1;
      end
      if (nak) begin
        mode_next = GM_RESET;
      end else begin
        res_sv_next = 1'b1;
        if (sample_count_next > CNT_W'(ungate)) begin
          mode_next = GM_RESET;
        end
        if (sample_count_next != COUNT_MAX) begin
          sample_count_next = sample_count_next + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= GM_CLOSED;
      sample_count <= '0;
      low_seen     <= 1'b0;
      pulse_count  <= '0;
      res_sv       <= 1'b0;
      res_stv      <= 1'b0;
      res_kind     <= 1'b0;
      res_op       <= 1'b0;
    end else if (cmd.gate_upd) begin
      mode         <= mode_next;
      sample_count <= sample_count_next;
      low_seen     <= low_seen_next;
      pulse_count  <= pulse_count_next;
      res_sv       <= res_sv_next;
      res_stv      <= res_stv_next;
      res_kind     <= res_kind_next;
      res_op       <= res_op_next;
    end
  end

  // span walk: read, then square, then accumulate
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_idx <= win_pos - WIN_AW'(span_n) - 1'b1;
      walk_cnt <= '0;
      walk_p1  <= 1'b0;
      walk_p2  <= 1'b0;
      st_sum   <= '0;
      st_sumsq <= '0;
      st_max   <= '0;
      st_min   <= '1;
    end else if (cmd.walk) begin
      walk_p1 <= walk_cnt != span_n;
      if (walk_cnt != span_n) begin
        walk_idx <= walk_idx + 1'b1;
        walk_cnt <= walk_cnt + 1'b1;
      end
      walk_p2 <= walk_p1;
      if (walk_p1) begin
        st_sum <= st_sum + SUM_W'(rd_val);
        sq_reg <= rd_val * rd_val;
        if (rd_val > st_max) begin
          st_max <= rd_val;
        end
        if (rd_val < st_min) begin
          st_min <= rd_val;
        end
      end
      if (walk_p2) begin
        st_sumsq <= st_sumsq + SSQ_W'(sq_reg);
      end
    end
  end

  // n * sumsq in two partial products, then sum squared, then variance
  always_ff @(posedge clk) begin
    if (cmd.nsq_lo) begin
      part_lo <= span_n * st_sumsq[SQ_SPLIT-1:0];
    end
    if (cmd.nsq_hi) begin
      part_hi <= span_n * st_sumsq[SSQ_W-1:SQ_SPLIT];
    end
    if (cmd.ssq) begin
      sum_sq <= st_sum * st_sum;
    end
    if (cmd.var_calc) begin
      var_r <= VAR_W'({part_hi, {SQ_SPLIT{1'b0}}}) + VAR_W'(part_lo) - sum_sq;
    end
    if (cmd.cap_mean && div_done) begin
      st_mean <= div_quo[MAG_W-1:0];
    end
    if (cmd.cap_std && div_done) begin
      st_std <= div_quo[MAG_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {res_stv ? st_std  : {MAG_W{1'b0}},
                  res_stv ? st_mean : {MAG_W{1'b0}},
                  res_stv ? st_min  : {MAG_W{1'b0}},
                  res_stv ? st_max  : {MAG_W{1'b0}},
                  res_sv  ? in_q    : {SMP_W{1'b0}},
                  res_sv  ? in_i    : {SMP_W{1'b0}}};
      m_tuser <= {res_op, res_stv & res_kind, res_stv, res_sv};
    end
  end

  // status
  assign sts.sqrt_done  = sqrt_done;
  assign sts.div_done   = div_done;
  assign sts.walk_done  = (walk_cnt == span_n) && !walk_p1 && !walk_p2;
  assign sts.need_stats = res_stv;
  assign sts.has_result = res_sv | res_stv | res_op;
  assign sts.out_free   = !m_tvalid || m_tready;

  // checks
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken result");
  a_pass_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[2*SMP_W-1:0] == '0)
    else $error("sample fields not zero on a dropped sample");
  a_stat_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[OUT_DATA_W-1:2*SMP_W] == '0 && !m_tuser[2])
    else $error("stat fields not zero without a measurement");
  a_some_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[0] || m_tuser[1] || m_tuser[3])
    else $error("result carries no flag");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> walk_cnt <= span_n)
    else $error("span walk ran past its length");

endmodule

@@ hdl/rcg_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcg_ctrl
// Sequencer for one sample: magnitude, window update, gate step and the
// optional statistics pass.
// ----------------------------------------------------------------------------
module rcg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  rcg_pkg::sts_t  sts,
  output rcg_pkg::cmd_t  cmd
);
  import rcg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_I, S_MUL_Q, S_MAG_GO, S_MAG_WAIT, S_WIN, S_THR, S_GATE,
    S_DECIDE, S_WALK_INIT, S_WALK, S_NSQ_LO, S_NSQ_HI, S_SSQ, S_VAR,
    S_SD_GO, S_SD_WAIT, S_MEAN_GO, S_MEAN_WAIT, S_STD_GO, S_STD_WAIT, S_OUT
  } state_t;

  state_t state;

  assign s_tready = state == S_IDLE;

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.accept    = state == S_IDLE && s_tvalid;
    cmd.mul_i     = state == S_MUL_I;
    cmd.mul_q     = state == S_MUL_Q;
    cmd.mag_go    = state == S_MAG_GO;
    cmd.win_upd   = state == S_MAG_WAIT && sts.sqrt_done;
    cmd.thr_mul   = state == S_THR;
    cmd.gate_upd  = state == S_GATE;
    cmd.walk_init = state == S_WALK_INIT;
    cmd.walk      = state == S_WALK;
    cmd.nsq_lo    = state == S_NSQ_LO;
    cmd.nsq_hi    = state == S_NSQ_HI;
    cmd.ssq       = state == S_SSQ;
    cmd.var_calc  = state == S_VAR;
    cmd.sd_go     = state == S_SD_GO;
    cmd.mean_go   = state == S_MEAN_GO;
    cmd.std_go    = state == S_STD_GO;
    cmd.cap_mean  = state == S_MEAN_WAIT;
    cmd.cap_std   = state == S_STD_WAIT;
    cmd.load_out  = state == S_OUT && sts.has_result && sts.out_free;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_MUL_I;
        end
        S_MUL_I:  state <= S_MUL_Q;
        S_MUL_Q:  state <= S_MAG_GO;
        S_MAG_GO: state <= S_MAG_WAIT;
        S_MAG_WAIT: begin
          if (sts.sqrt_done) state <= S_WIN;
        end
        S_WIN:  state <= S_THR;
        S_THR:  state <= S_GATE;
        S_GATE: state <= S_DECIDE;
        S_DECIDE: begin
          state <= sts.need_stats ? S_WALK_INIT : S_OUT;
        end
        S_WALK_INIT: state <= S_WALK;
        S_WALK: begin
          if (sts.walk_done) state <= S_NSQ_LO;
        end
        S_NSQ_LO: state <= S_NSQ_HI;
        S_NSQ_HI: state <= S_SSQ;
        S_SSQ:    state <= S_VAR;
        S_VAR:    state <= S_SD_GO;
        S_SD_GO:  state <= S_SD_WAIT;
        S_SD_WAIT: begin
          if (sts.sqrt_done) state <= S_MEAN_GO;
        end
        S_MEAN_GO: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (sts.div_done) state <= S_STD_GO;
        end
        S_STD_GO: state <= S_STD_WAIT;
        S_STD_WAIT: begin
          if (sts.div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!sts.has_result || sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/reader_command_gate_core.sv @@
// ----------------------------------------------------------------------------
// reader_command_gate_core
// Reader command gate: sample magnitude, moving-window edge detection,
// pulse-counting gate and span statistics.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   tdata: sample_i, sample_q; tuser: nak_flag
//   m_*      out  m_tvalid/m_tready   tdata: out_i..stat_std_dev; tuser: flags
//   cfg_*    in   cfg_we              cfg_index, cfg_data
//
// An ordinary sample waits on the iterative square root for its magnitude. A
// sample that reports statistics adds the span walk over n = t1 / 4 window
// entries, the variance root and two divisions by n. One sample is worked on
// at a time; the next one is taken while an earlier result waits in the
// output register. Reset is synchronous and clears the window at once
// through per-entry valid bits.
// ----------------------------------------------------------------------------
module reader_command_gate_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rcg_pkg::IN_DATA_W-1:0]  s_tdata,  // sample_i, sample_q
  input  logic                           s_tuser,  // nak_flag
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_i, out_q, stat_max, stat_min, stat_mean, stat_std_dev
  output logic [rcg_pkg::OUT_DATA_W-1:0] m_tdata,
  // sample_valid, stats_valid, stats_kind, gate_opened
  output logic [rcg_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                           cfg_we,
  input  logic [rcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcg_pkg::CFG_W-1:0]      cfg_data
);
  import rcg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  rcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  rcg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .in_nak    (s_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
